FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

FILE: rtl/rccl_pkg.sv
// ----------------------------------------------------------------------------
// rccl_pkg
// widths, codes and shared types of the colour classifier / line follower
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rccl_pkg;

    localparam int CHANNEL_BITS = 10;
    localparam int SUM_W        = CHANNEL_BITS + 2;
    localparam int DIFF_W       = CHANNEL_BITS + 3;
    localparam int PREV_W       = 13;
    localparam int DD_W         = ((DIFF_W > PREV_W) ? DIFF_W : PREV_W) + 1;
    localparam int GAIN_W       = 16;
    localparam int CORR_W       = DD_W + GAIN_W + 1;
    localparam int DRV_SUM_W    = CORR_W + 1;
    localparam int NUM_W        = CHANNEL_BITS + 6;
    localparam int QUOT_W       = 6;
    localparam int HUE_W        = 9;
    localparam int DRIVE_W      = 11;
    localparam int CLASS_W      = 3;
    localparam int BASE_W       = 11;
    localparam int LEVEL_W      = 12;
    localparam int CHROMA_W     = 10;
    localparam int REG_IDX_W    = 3;
    localparam int APB_AW       = REG_IDX_W + 2;
    localparam int APB_DW       = 32;

    localparam logic signed [DD_W-1:0] PREV_HI = DD_W'(2 ** (PREV_W - 1) - 1);
    localparam logic signed [DD_W-1:0] PREV_LO = -DD_W'(2 ** (PREV_W - 1));
    localparam logic signed [DRV_SUM_W-1:0] DRV_HI = DRV_SUM_W'(2 ** (DRIVE_W - 1) - 1);
    localparam logic signed [DRV_SUM_W-1:0] DRV_LO = -DRV_SUM_W'(2 ** (DRIVE_W - 1));

    localparam logic [HUE_W-1:0] HUE_GREEN  = HUE_W'(120);
    localparam logic [HUE_W-1:0] HUE_BLUE   = HUE_W'(240);
    localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(360);
    localparam logic [HUE_W-1:0] HUE_RED_HI = HUE_W'(330);
    localparam logic [HUE_W-1:0] HUE_RED_LO = HUE_W'(30);

    // register map, word index
    localparam logic [REG_IDX_W-1:0] REG_BASE_SPEED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLACK_LEVEL  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WHITE_LEVEL  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CHROMA_MIN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_LOW    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_HIGH   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd7;

    typedef enum logic [CLASS_W-1:0] {
        CLS_OTHER = 3'd0,
        CLS_BLACK = 3'd1,
        CLS_WHITE = 3'd2,
        CLS_GREEN = 3'd3,
        CLS_RED   = 3'd4
    } class_t;

    typedef struct packed {
        logic                    start;
        logic [NUM_W-1:0]        num;
        logic [CHANNEL_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic              rem_nz;
    } div_res_t;

    typedef struct packed {
        logic                     done;
        logic signed [CORR_W-1:0] corr;
    } mac_res_t;

endpackage

FILE: rtl/rccl_if.sv
// ----------------------------------------------------------------------------
// rccl_if
// valid/ready channels for sensor samples and drive results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rccl_samp_if;
    import rccl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] left_red;
    logic [CHANNEL_BITS-1:0] left_green;
    logic [CHANNEL_BITS-1:0] left_blue;
    logic [CHANNEL_BITS-1:0] right_red;
    logic [CHANNEL_BITS-1:0] right_green;
    logic [CHANNEL_BITS-1:0] right_blue;

    modport source (
        output valid, left_red, left_green, left_blue, right_red, right_green, right_blue,
        input  ready
    );
    modport sink (
        input  valid, left_red, left_green, left_blue, right_red, right_green, right_blue,
        output ready
    );
endinterface

interface rccl_drv_if;
    import rccl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic [CLASS_W-1:0]        left_class;
    logic [CLASS_W-1:0]        right_class;
    logic [HUE_W-1:0]          left_hue;
    logic [HUE_W-1:0]          right_hue;

    modport source (
        output valid, left_drive, right_drive, left_class, right_class, left_hue, right_hue,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, left_class, right_class, left_hue, right_hue,
        output ready
    );
endinterface

FILE: rtl/rccl_div.sv
// ----------------------------------------------------------------------------
// rccl_div
// bit-serial restoring divider for the hue fraction, one quotient bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rccl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rccl_pkg::div_req_t req,
    output rccl_pkg::div_res_t res
);
    import rccl_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CHANNEL_BITS-1:0] rem_reg;
    logic [CHANNEL_BITS-1:0] den_reg;
    logic [QUOT_W-1:0]       low_reg;
    logic [QUOT_W-1:0]       quot_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic [CHANNEL_BITS:0]   rem_sh;
    logic [CHANNEL_BITS:0]   trial;
    logic                    qbit;

    // numerator is below 64 times the divisor, so the upper bits seed the remainder
    assign rem_sh = {rem_reg, low_reg[QUOT_W-1]};
    assign trial  = rem_sh - {1'b0, den_reg};
    assign qbit   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= CNT_W'(QUOT_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num[NUM_W-1:QUOT_W];
            low_reg  <= req.num[QUOT_W-1:0];
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? trial[CHANNEL_BITS-1:0] : rem_sh[CHANNEL_BITS-1:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], qbit};
        end
    end

    assign res.done   = done_reg;
    assign res.quot   = quot_reg;
    assign res.rem_nz = |rem_reg;

endmodule

FILE: rtl/rccl_mac.sv
// ----------------------------------------------------------------------------
// rccl_mac
// bit-serial pd correction: prop_gain*diff + deriv_gain*(prev - diff)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rccl_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [rccl_pkg::DIFF_W-1:0]   diff,
    input  logic signed [rccl_pkg::PREV_W-1:0]   prev,
    input  logic [rccl_pkg::GAIN_W-1:0]          prop_gain,
    input  logic [rccl_pkg::GAIN_W-1:0]          deriv_gain,
    output rccl_pkg::mac_res_t                   res
);
    import rccl_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [GAIN_W-1:0]        pg_reg;
    logic [GAIN_W-1:0]        dg_reg;
    logic signed [CORR_W-1:0] a_reg;
    logic signed [CORR_W-1:0] b_reg;
    logic signed [CORR_W-1:0] acc_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic signed [DD_W-1:0]   dd;
    logic signed [CORR_W-1:0] add_a;
    logic signed [CORR_W-1:0] add_b;

    assign dd    = DD_W'(prev) - DD_W'(diff);
    assign add_a = pg_reg[0] ? a_reg : '0;
    assign add_b = dg_reg[0] ? b_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(GAIN_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // one gain bit of each product per cycle, lsb first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pg_reg  <= prop_gain;
            dg_reg  <= deriv_gain;
            a_reg   <= CORR_W'(diff);
            b_reg   <= CORR_W'(dd);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pg_reg  <= pg_reg >> 1;
            dg_reg  <= dg_reg >> 1;
            a_reg   <= a_reg <<< 1;
            b_reg   <= b_reg <<< 1;
            acc_reg <= acc_reg + add_a + add_b;
        end
    end

    assign res.done = done_reg;
    assign res.corr = acc_reg;

endmodule

FILE: rtl/rgb_color_classify_line_follow.sv
// ----------------------------------------------------------------------------
// rgb_color_classify_line_follow
// left/right rgb colour classifier with a pd line-following drive output
// ----------------------------------------------------------------------------
// Each input beat carries one rgb sample per side and produces one output beat
// with both wheel drives, both colour classes and both hues. One sample is in
// flight at a time. The 16-step bit-serial gain multiply runs alongside a single
// shared 6-step divider that works out both hue fractions in turn. A finished
// result waits in the output register while the next sample is taken in.
// Registers sit on an apb port at byte address 4*index and should be written
// while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_color_classify_line_follow (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rccl_pkg::APB_AW-1:0]  paddr,
    input  logic [rccl_pkg::APB_DW-1:0]  pwdata,
    output logic [rccl_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    rccl_samp_if.sink                    samp,
    rccl_drv_if.source                   drv
);
    import rccl_pkg::*;

    localparam int CB      = CHANNEL_BITS;
    localparam int CMP_W   = (SUM_W > LEVEL_W) ? SUM_W : LEVEL_W;
    localparam int CHR_W   = (CB > CHROMA_W) ? CB : CHROMA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_NUM,
        ST_DIVL,
        ST_DIVR,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        MX_BLUE,
        MX_RED,
        MX_GREEN
    } maxsel_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CB-1:0]     d;
        logic signed [CB:0] delta;
        maxsel_t           sel;
        logic              gray;
    } side_t;

    // configuration
    logic signed [BASE_W-1:0] base_speed_reg;
    logic [LEVEL_W-1:0]       black_level_reg;
    logic [LEVEL_W-1:0]       white_level_reg;
    logic [CHROMA_W-1:0]      chroma_min_reg;
    logic [HUE_W-1:0]         green_low_reg;
    logic [HUE_W-1:0]         green_high_reg;
    logic [GAIN_W-1:0]        prop_gain_reg;
    logic [GAIN_W-1:0]        deriv_gain_reg;

    // control
    state_t                   state_reg, state_next;
    logic                     div_start_reg, div_start_next;
    logic                     mac_start_reg, mac_start_next;
    logic                     mac_seen_reg, mac_seen_next;
    logic                     ov_reg, ov_next;
    logic signed [PREV_W-1:0] prev_diff_reg, prev_diff_next;
    logic                     load_out;

    // datapath
    logic [CB-1:0]            lr_reg, lg_reg, lb_reg, rr_reg, rg_reg, rb_reg;
    side_t                    lside_reg, rside_reg;
    logic [NUM_W-1:0]         lnum_reg, rnum_reg;
    logic                     lneg_reg, rneg_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [HUE_W-1:0]         lhue_reg, rhue_reg;

    logic signed [DRIVE_W-1:0] ldrv_reg, rdrv_reg;
    logic [CLASS_W-1:0]        lcls_reg, rcls_reg;
    logic [HUE_W-1:0]          lhue_out_reg, rhue_out_reg;

    logic                      samp_fire;
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;
    div_req_t                  div_req;
    div_res_t                  div_res;
    mac_res_t                  mac_res;
    logic [HUE_W-1:0]          hue_new;
    logic signed [DRV_SUM_W-1:0] tot_l, tot_r;

    // ------------------------------------------------------------------
    function automatic side_t side_prep(input logic [CB-1:0] r,
                                        input logic [CB-1:0] g,
                                        input logic [CB-1:0] b);
        side_t         s;
        logic [CB-1:0] mn;
        s.sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
        s.gray = (r == g) && (g == b);
        mn     = (r < g) ? r : g;
        if (b < mn)
        begin
            mn = b;
        end
        if (b >= r && b >= g)
        begin
            s.sel   = MX_BLUE;
            s.d     = b - mn;
            s.delta = $signed({1'b0, r}) - $signed({1'b0, g});
        end
        else if (r >= g)
        begin
            s.sel   = MX_RED;
            s.d     = r - mn;
            s.delta = $signed({1'b0, g}) - $signed({1'b0, b});
        end
        else
        begin
            s.sel   = MX_GREEN;
            s.d     = g - mn;
            s.delta = $signed({1'b0, b}) - $signed({1'b0, r});
        end
        return s;
    endfunction

    // 60 * |delta| as a shift and subtract
    function automatic logic [NUM_W-1:0] num_of(input logic signed [CB:0] delta);
        logic [CB-1:0] mag;
        mag = delta[CB] ? CB'(-delta) : CB'(delta);
        return (NUM_W'(mag) << 6) - (NUM_W'(mag) << 2);
    endfunction

    function automatic logic [HUE_W-1:0] hue_of(input side_t s,
                                                input logic neg,
                                                input logic [QUOT_W-1:0] q,
                                                input logic rnz);
        logic [HUE_W-1:0] qe;
        logic [HUE_W-1:0] rz;
        logic [HUE_W-1:0] h;
        qe = HUE_W'(q);
        rz = HUE_W'(rnz);
        case (s.sel)
            MX_BLUE:  h = neg ? (HUE_BLUE - qe - rz) : (HUE_BLUE + qe);
            MX_RED:   h = (neg && (q != '0)) ? (HUE_FULL - qe) : qe;
            default:  h = neg ? (HUE_GREEN - qe - rz) : (HUE_GREEN + qe);
        endcase
        // gray sample has no hue
        if (s.gray)
        begin
            h = '0;
        end
        return h;
    endfunction

    function automatic logic [CLASS_W-1:0] class_of(input side_t s,
                                                    input logic [HUE_W-1:0] hue,
                                                    input logic [LEVEL_W-1:0] blk,
                                                    input logic [LEVEL_W-1:0] wht,
                                                    input logic [CHROMA_W-1:0] cmin,
                                                    input logic [HUE_W-1:0] glo,
                                                    input logic [HUE_W-1:0] ghi);
        class_t c;
        logic   chroma_ok;
        chroma_ok = CHR_W'(s.d) > CHR_W'(cmin);
        if (CMP_W'(s.sum) <= CMP_W'(blk))
        begin
            c = CLS_BLACK;
        end
        else if (CMP_W'(s.sum) >= CMP_W'(wht))
        begin
            c = CLS_WHITE;
        end
        else if (chroma_ok && glo <= hue && hue <= ghi)
        begin
            c = CLS_GREEN;
        end
        else if (chroma_ok && (hue >= HUE_RED_HI || hue <= HUE_RED_LO))
        begin
            c = CLS_RED;
        end
        else
        begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

    // divide by 256 toward zero, then clamp to the drive range
    function automatic logic signed [DRIVE_W-1:0] drive_of(
        input logic signed [DRV_SUM_W-1:0] tot);
        logic signed [DRV_SUM_W-1:0] q;
        q = tot >>> 8;
        if (tot[DRV_SUM_W-1] && (tot[7:0] != 8'd0))
        begin
            q = q + {{(DRV_SUM_W-1){1'b0}}, 1'b1};
        end
        if (q > DRV_HI)
        begin
            q = DRV_HI;
        end
        else if (q < DRV_LO)
        begin
            q = DRV_LO;
        end
        return DRIVE_W'(q);
    endfunction

    function automatic logic signed [PREV_W-1:0] sat_prev(
        input logic signed [DIFF_W-1:0] dv);
        logic signed [DD_W-1:0] w;
        w = DD_W'(dv);
        if (w > PREV_HI)
        begin
            w = PREV_HI;
        end
        else if (w < PREV_LO)
        begin
            w = PREV_LO;
        end
        return PREV_W'(w);
    endfunction

    // ------------------------------------------------------------------
    // apb registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_speed_reg  <= BASE_W'(140);
            black_level_reg <= LEVEL_W'(50);
            white_level_reg <= LEVEL_W'(100);
            chroma_min_reg  <= CHROMA_W'(10);
            green_low_reg   <= HUE_W'(135);
            green_high_reg  <= HUE_W'(145);
            prop_gain_reg   <= GAIN_W'(282);
            deriv_gain_reg  <= GAIN_W'(3840);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BASE_SPEED:  base_speed_reg  <= pwdata[BASE_W-1:0];
                REG_BLACK_LEVEL: black_level_reg <= pwdata[LEVEL_W-1:0];
                REG_WHITE_LEVEL: white_level_reg <= pwdata[LEVEL_W-1:0];
                REG_CHROMA_MIN:  chroma_min_reg  <= pwdata[CHROMA_W-1:0];
                REG_GREEN_LOW:   green_low_reg   <= pwdata[HUE_W-1:0];
                REG_GREEN_HIGH:  green_high_reg  <= pwdata[HUE_W-1:0];
                REG_PROP_GAIN:   prop_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= pwdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BASE_SPEED:  prdata = APB_DW'(unsigned'(base_speed_reg));
            REG_BLACK_LEVEL: prdata = APB_DW'(black_level_reg);
            REG_WHITE_LEVEL: prdata = APB_DW'(white_level_reg);
            REG_CHROMA_MIN:  prdata = APB_DW'(chroma_min_reg);
            REG_GREEN_LOW:   prdata = APB_DW'(green_low_reg);
            REG_GREEN_HIGH:  prdata = APB_DW'(green_high_reg);
            REG_PROP_GAIN:   prdata = APB_DW'(prop_gain_reg);
            REG_DERIV_GAIN:  prdata = APB_DW'(deriv_gain_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // shared units
    assign div_req.start = div_start_reg;
    assign div_req.num   = (state_reg == ST_DIVR) ? rnum_reg : lnum_reg;
    assign div_req.den   = (state_reg == ST_DIVR) ? rside_reg.d : lside_reg.d;

    rccl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    rccl_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mac_start_reg),
        .diff       (diff_reg),
        .prev       (prev_diff_reg),
        .prop_gain  (prop_gain_reg),
        .deriv_gain (deriv_gain_reg),
        .res        (mac_res)
    );

    // ------------------------------------------------------------------
    // sequencer
    assign samp.ready = (state_reg == ST_IDLE);
    assign samp_fire  = samp.valid && samp.ready;

    always_comb
    begin
        state_next     = state_reg;
        div_start_next = 1'b0;
        mac_start_next = 1'b0;
        mac_seen_next  = mac_seen_reg || mac_res.done;
        ov_next        = ov_reg;
        load_out       = 1'b0;
        prev_diff_next = mac_start_reg ? sat_prev(diff_reg) : prev_diff_reg;

        if (ov_reg && drv.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (samp.valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                div_start_next = 1'b1;
                mac_start_next = 1'b1;
                mac_seen_next  = 1'b0;
                state_next     = ST_DIVL;
            end
            ST_DIVL:
            begin
                if (div_res.done)
                begin
                    div_start_next = 1'b1;
                    state_next     = ST_DIVR;
                end
            end
            ST_DIVR:
            begin
                if (div_res.done)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (mac_seen_reg || mac_res.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // result register free, or its beat taken this cycle
                if (!ov_reg || drv.ready)
                begin
                    load_out   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            mac_start_reg <= 1'b0;
            mac_seen_reg  <= 1'b0;
            ov_reg        <= 1'b0;
            prev_diff_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            mac_start_reg <= mac_start_next;
            mac_seen_reg  <= mac_seen_next;
            ov_reg        <= ov_next;
            prev_diff_reg <= prev_diff_next;
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    assign hue_new = (state_reg == ST_DIVR)
                   ? hue_of(rside_reg, rneg_reg, div_res.quot, div_res.rem_nz)
                   : hue_of(lside_reg, lneg_reg, div_res.quot, div_res.rem_nz);

    assign tot_l = (DRV_SUM_W'(base_speed_reg) <<< 8) + DRV_SUM_W'(mac_res.corr);
    assign tot_r = (DRV_SUM_W'(base_speed_reg) <<< 8) - DRV_SUM_W'(mac_res.corr);

    always_ff @(posedge clk)
    begin
        if (samp_fire)
        begin
            lr_reg <= samp.left_red;
            lg_reg <= samp.left_green;
            lb_reg <= samp.left_blue;
            rr_reg <= samp.right_red;
            rg_reg <= samp.right_green;
            rb_reg <= samp.right_blue;
        end
        if (state_reg == ST_PREP)
        begin
            lside_reg <= side_prep(lr_reg, lg_reg, lb_reg);
            rside_reg <= side_prep(rr_reg, rg_reg, rb_reg);
        end
        if (state_reg == ST_NUM)
        begin
            lnum_reg <= num_of(lside_reg.delta);
            rnum_reg <= num_of(rside_reg.delta);
            lneg_reg <= lside_reg.delta[CB];
            rneg_reg <= rside_reg.delta[CB];
            diff_reg <= DIFF_W'(lside_reg.sum) - DIFF_W'(rside_reg.sum);
        end
        if (div_res.done && state_reg == ST_DIVL)
        begin
            lhue_reg <= hue_new;
        end
        if (div_res.done && state_reg == ST_DIVR)
        begin
            rhue_reg <= hue_new;
        end
        if (load_out)
        begin
            ldrv_reg     <= drive_of(tot_l);
            rdrv_reg     <= drive_of(tot_r);
            lcls_reg     <= class_of(lside_reg, lhue_reg, black_level_reg, white_level_reg,
                                     chroma_min_reg, green_low_reg, green_high_reg);
            rcls_reg     <= class_of(rside_reg, rhue_reg, black_level_reg, white_level_reg,
                                     chroma_min_reg, green_low_reg, green_high_reg);
            lhue_out_reg <= lhue_reg;
            rhue_out_reg <= rhue_reg;
        end
    end

    assign drv.valid       = ov_reg;
    assign drv.left_drive  = ldrv_reg;
    assign drv.right_drive = rdrv_reg;
    assign drv.left_class  = lcls_reg;
    assign drv.right_class = rcls_reg;
    assign drv.left_hue    = lhue_out_reg;
    assign drv.right_hue   = rhue_out_reg;

    // ------------------------------------------------------------------
    `ASSERT_CLK(a_div_done_in_div, div_res.done |-> (state_reg == ST_DIVL || state_reg == ST_DIVR), "divider finished outside a divide phase")
    `ASSERT_CLK(a_mac_done_in_run, mac_res.done |-> (state_reg == ST_DIVL || state_reg == ST_DIVR || state_reg == ST_WAIT), "pd multiply finished outside the run phase")
    `ASSERT_CLK(a_prev_on_start, !$stable(prev_diff_reg) |-> $past(mac_start_reg), "previous error changed without a multiply start")

endmodule
